>>> sv/ahs_pkg.sv
// ----------------------------------------------------------------------------
// ahs_pkg
// Shared types and constants for the advertising data service UUID scanner.
// ----------------------------------------------------------------------------
package ahs_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned UUID_W = 16;

    // Human interface device service UUID
    localparam logic [UUID_W-1:0] UUID_RESET = 16'h1812;

    // One advertising data byte as it moves from the input register to the parser
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_byte_item;

endpackage

>>> sv/ahs_in_reg.sv
// ----------------------------------------------------------------------------
// ahs_in_reg
// Input register: captures one byte transfer and holds it until the parser
// takes it.
// ----------------------------------------------------------------------------
module ahs_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  ahs_pkg::t_byte_item i_item,
    output logic               o_stall,
    input  logic               i_take,
    output logic               o_valid,
    output ahs_pkg::t_byte_item o_item
);
    import ahs_pkg::*;

    logic       r_valid;
    logic       n_valid;
    t_byte_item r_item;
    logic       accept;

    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> sv/ahs_parser.sv
// ----------------------------------------------------------------------------
// ahs_parser
// Length-type-data walker: tracks structure boundaries, assembles UUID
// pairs and keeps the sticky found flag.
// ----------------------------------------------------------------------------
module ahs_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  ahs_pkg::t_byte_item         i_item,
    input  logic [ahs_pkg::UUID_W-1:0]  i_target,
    output logic                        o_result_valid,
    output logic                        o_hid_found
);
    import ahs_pkg::*;

    localparam logic [1:0] PH_LEN  = 2'd0;
    localparam logic [1:0] PH_TYPE = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    localparam logic [BYTE_W-1:0] TYPE_U16_INCOMPLETE = 8'h02;
    localparam logic [BYTE_W-1:0] TYPE_U16_COMPLETE   = 8'h03;
    localparam logic [BYTE_W-1:0] TYPE_U128_COMPLETE  = 8'h07;

    localparam logic [3:0] U128_UUID_LO = 4'd12;
    localparam logic [3:0] U128_UUID_HI = 4'd13;
    localparam logic [3:0] U128_END     = 4'd15;

    logic [1:0]        r_phase,   n_phase;
    logic [BYTE_W-1:0] r_left,    n_left;
    logic [BYTE_W-1:0] r_type,    n_type;
    logic [3:0]        r_pos,     n_pos;
    logic [BYTE_W-1:0] r_low,     n_low;
    logic              r_pending, n_pending;
    logic              r_found,   n_found;

    logic              pair_hit;
    logic [BYTE_W-1:0] left_dec;

    assign pair_hit = ({i_item.data, r_low} == i_target);
    assign left_dec = r_left - 8'd1;

    always_comb begin
        n_phase   = r_phase;
        n_left    = r_left;
        n_type    = r_type;
        n_pos     = r_pos;
        n_low     = r_low;
        n_pending = r_pending;
        n_found   = r_found;

        unique case (r_phase)
            PH_TYPE: begin
                n_type    = i_item.data;
                n_left    = left_dec;
                n_pos     = 4'd0;
                n_pending = 1'b0;
                n_phase   = (left_dec != 8'd0) ? PH_DATA : PH_LEN;
            end
            PH_DATA: begin
                if (r_type == TYPE_U16_INCOMPLETE || r_type == TYPE_U16_COMPLETE) begin
                    if (r_pos == 4'd0) begin
                        n_low = i_item.data;
                        n_pos = 4'd1;
                    end else begin
                        if (pair_hit) begin
                            n_found = 1'b1;
                        end
                        n_pos = 4'd0;
                    end
                end else if (r_type == TYPE_U128_COMPLETE) begin
                    if (r_pos == 4'd0) begin
                        n_pending = 1'b0;
                    end
                    if (r_pos == U128_UUID_LO) begin
                        n_low = i_item.data;
                    end else if (r_pos == U128_UUID_HI) begin
                        n_pending = pair_hit;
                    end else if (r_pos == U128_END) begin
                        // entry complete: a held match now counts
                        if (r_pending) begin
                            n_found = 1'b1;
                        end
                        n_pending = 1'b0;
                    end
                    n_pos = r_pos + 4'd1;
                end
                n_left = left_dec;
                if (left_dec == 8'd0) begin
                    n_phase = PH_LEN;
                end
            end
            default: begin
                // zero length byte is skipped
                if (i_item.data != 8'd0) begin
                    n_left  = i_item.data;
                    n_phase = PH_TYPE;
                end else begin
                    n_phase = PH_LEN;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LEN;
            r_left    <= '0;
            r_type    <= '0;
            r_pos     <= '0;
            r_low     <= '0;
            r_pending <= 1'b0;
            r_found   <= 1'b0;
        end else if (i_step) begin
            if (i_item.last) begin
                // end of data: start the next frame from scratch
                r_phase   <= PH_LEN;
                r_left    <= '0;
                r_type    <= '0;
                r_pos     <= '0;
                r_low     <= '0;
                r_pending <= 1'b0;
                r_found   <= 1'b0;
            end else begin
                r_phase   <= n_phase;
                r_left    <= n_left;
                r_type    <= n_type;
                r_pos     <= n_pos;
                r_low     <= n_low;
                r_pending <= n_pending;
                r_found   <= n_found;
            end
        end
    end

    assign o_result_valid = i_step && i_item.last;
    assign o_hid_found    = n_found;

`ifndef NO_ASSERTIONS
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.last) |=> (r_phase == PH_LEN && !r_found && !r_pending))
        else $error("parser state not cleared after final byte");

    a_pending_only_u128: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> (r_type == TYPE_U128_COMPLETE))
        else $error("pending match outside a 128-bit list");

    a_u16_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA &&
         (r_type == TYPE_U16_INCOMPLETE || r_type == TYPE_U16_COMPLETE)) |-> (r_pos <= 4'd1))
        else $error("pair position out of range in 16-bit list");

    a_found_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_found && !(i_step && i_item.last)) |=> r_found)
        else $error("found flag dropped inside a frame");
`endif

endmodule

>>> sv/ahs_out_reg.sv
// ----------------------------------------------------------------------------
// ahs_out_reg
// Result register: holds the found flag until the receiver takes it.
// ----------------------------------------------------------------------------
module ahs_out_reg (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  logic i_hid_found,
    output logic o_free,
    output logic o_valid,
    output logic o_hid_found,
    input  logic i_stall
);
    logic r_valid;
    logic n_valid;
    logic r_hid_found;

    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_hid_found <= i_hid_found;
        end
    end

    assign o_valid     = r_valid;
    assign o_hid_found = r_hid_found;

endmodule

>>> sv/adv_hid_service_scanner_core.sv
// ----------------------------------------------------------------------------
// adv_hid_service_scanner_core
// Scans advertising data bytes for a 16-bit service UUID.
// ----------------------------------------------------------------------------
// Input channel: one advertising data byte per transfer (i_in_valid high,
// o_in_stall low), with i_last marking the final byte of the data.
// Output channel: one transfer per frame, at the final byte, carrying
// o_hid_found; taken when o_out_valid is high and i_out_stall is low.
// Config channel: i_cfg_target_uuid is written when i_cfg_valid and
// o_cfg_ready are high; write only while no frame is in flight.
// Throughput: one byte per cycle while no final byte waits on a full result
// register. The final byte passes through the input register, then the result
// register loads its found flag, from which the result transfer is taken.
// The parser state update is one pass of small logic per byte.
// Reset: target UUID returns to 0x1812, parsing restarts at a length byte,
// no result is pending.
// Receiver stall: a held result blocks only the next final byte; other bytes
// keep flowing through the parser.
// ----------------------------------------------------------------------------
module adv_hid_service_scanner_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [ahs_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                       i_last,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_hid_found,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [ahs_pkg::UUID_W-1:0] i_cfg_target_uuid
);
    import ahs_pkg::*;

    logic [UUID_W-1:0] r_target;
    t_byte_item        in_item;
    t_byte_item        held_item;
    logic              held_valid;
    logic              out_free;
    logic              advance;
    logic              step;
    logic              result_valid;
    logic              result_found;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= UUID_RESET;
        end else if (i_cfg_valid) begin
            r_target <= i_cfg_target_uuid;
        end
    end

    assign in_item.data = i_data_byte;
    assign in_item.last = i_last;

    // a final byte waits only while the result register is full and stalled
    assign advance = out_free || !held_item.last;
    assign step    = held_valid && advance;

    ahs_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (in_item),
        .o_stall (o_in_stall),
        .i_take  (advance),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    ahs_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_item         (held_item),
        .i_target       (r_target),
        .o_result_valid (result_valid),
        .o_hid_found    (result_found)
    );

    ahs_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (result_valid),
        .i_hid_found (result_found),
        .o_free      (out_free),
        .o_valid     (o_out_valid),
        .o_hid_found (o_hid_found),
        .i_stall     (i_out_stall)
    );

endmodule

>>> tb/sv/ahs_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ahs_tb_pkg
// Advertising data codes shared by the scanner stimulus and the checker.
// ----------------------------------------------------------------------------
package ahs_tb_pkg;

    // Structure types that carry service UUID lists
    localparam logic [7:0] AD_UUID16_PARTIAL = 8'h02;
    localparam logic [7:0] AD_UUID16_FULL    = 8'h03;
    localparam logic [7:0] AD_UUID128_FULL   = 8'h07;

    // Byte positions inside one 16-byte UUID entry
    localparam logic [3:0] U128_LO_POS    = 4'd12;
    localparam logic [3:0] U128_HI_POS    = 4'd13;
    localparam logic [3:0] U128_END_POS   = 4'd15;
    localparam int         U128_ENTRY_LEN = 16;

endpackage

>>> tb/sv/ahs_scan_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ahs_scan_checker
// Watches the byte, result and target channels of the scanner, tracks the
// length-type-data parse of each frame, and compares every found flag with
// the one due for the oldest finished frame.
// ----------------------------------------------------------------------------
module ahs_scan_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic [ahs_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                       i_last,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic                       i_hid_found,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [ahs_pkg::UUID_W-1:0] i_cfg_target_uuid,
    output int                         o_fail_count,
    output int                         o_pending
);
    import ahs_pkg::*;
    import ahs_tb_pkg::*;

    typedef enum logic [1:0] { SCAN_LEN, SCAN_TYPE, SCAN_DATA } t_scan_phase;

    localparam int MAX_REPORTS = 10;

    logic [UUID_W-1:0] target_uuid;
    t_scan_phase       scan_phase;
    logic [7:0]        ad_left;
    logic [7:0]        ad_type;
    logic [7:0]        low_byte;
    logic [3:0]        entry_pos;
    logic              entry_hit;
    logic              uuid_seen;
    logic              found_due[$];
    int                mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic clear_scan();
        scan_phase = SCAN_LEN;
        ad_left    = '0;
        ad_type    = '0;
        entry_pos  = '0;
        low_byte   = '0;
        entry_hit  = 1'b0;
        uuid_seen  = 1'b0;
    endtask

    task automatic note_failure(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] %s", $time, what);
        end
    endtask

    always @(posedge i_clk) begin : scan_model
        logic [UUID_W-1:0] pair;
        logic              want_found;
        if (!i_rst_n) begin
            target_uuid = UUID_RESET;
            clear_scan();
            found_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                target_uuid = i_cfg_target_uuid;
            end

            // Results leave after their last byte is taken, so check before the new byte
            if (i_out_valid && !i_out_stall) begin
                if (found_due.size() == 0) begin
                    note_failure($sformatf("result with no frame pending: hid_found=%0b",
                                           i_hid_found));
                end else begin
                    want_found = found_due.pop_front();
                    if (i_hid_found !== want_found) begin
                        note_failure($sformatf("hid_found mismatch: expected %0b, got %0b",
                                               want_found, i_hid_found));
                    end
                end
            end

            if (i_in_valid && !i_in_stall) begin
                case (scan_phase)
                    SCAN_TYPE: begin
                        ad_type    = i_data_byte;
                        ad_left    = ad_left - 8'd1;
                        entry_pos  = '0;
                        entry_hit  = 1'b0;
                        scan_phase = (ad_left != 0) ? SCAN_DATA : SCAN_LEN;
                    end
                    SCAN_DATA: begin
                        if (ad_type == AD_UUID16_PARTIAL || ad_type == AD_UUID16_FULL) begin
                            if (entry_pos == 0) begin
                                low_byte  = i_data_byte;
                                entry_pos = 4'd1;
                            end else begin
                                pair = {i_data_byte, low_byte};
                                if (pair == target_uuid) begin
                                    uuid_seen = 1'b1;
                                end
                                entry_pos = '0;
                            end
                        end else if (ad_type == AD_UUID128_FULL) begin
                            if (entry_pos == 0) begin
                                entry_hit = 1'b0;
                            end
                            if (entry_pos == U128_LO_POS) begin
                                low_byte = i_data_byte;
                            end else if (entry_pos == U128_HI_POS) begin
                                entry_hit = ({i_data_byte, low_byte} == target_uuid);
                            end else if (entry_pos == U128_END_POS) begin
                                // a 128-bit hit counts only once its entry is whole
                                if (entry_hit) begin
                                    uuid_seen = 1'b1;
                                end
                                entry_hit = 1'b0;
                            end
                            entry_pos = entry_pos + 4'd1;
                        end
                        ad_left = ad_left - 8'd1;
                        if (ad_left == 0) begin
                            scan_phase = SCAN_LEN;
                        end
                    end
                    default: begin
                        // zero length: skip, stay on a length byte
                        if (i_data_byte != 0) begin
                            ad_left    = i_data_byte;
                            scan_phase = SCAN_TYPE;
                        end else begin
                            scan_phase = SCAN_LEN;
                        end
                    end
                endcase
                if (i_last) begin
                    found_due.push_back(uuid_seen);
                    clear_scan();
                end
            end
        end
        o_pending <= found_due.size();
    end

endmodule

>>> tb/sv/adv_hid_service_scanner_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adv_hid_service_scanner_core_tb
// Feeds advertising data frames to the service UUID scanner: a few directed
// frames, then random frames of 16-bit lists, 128-bit lists, other types,
// truncations and noise under four target UUIDs, with random gaps and stalls.
// ----------------------------------------------------------------------------
module adv_hid_service_scanner_core_tb;
    import ahs_pkg::*;
    import ahs_tb_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 7;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int BYTES_PER_PHASE = 150;
    localparam int N_PHASES        = 4;

    logic              i_clk             = 1'b0;
    logic              i_rst_n           = 1'b0;
    logic              i_in_valid        = 1'b0;
    logic [BYTE_W-1:0] i_data_byte       = '0;
    logic              i_last            = 1'b0;
    logic              i_out_stall       = 1'b0;
    logic              i_cfg_valid       = 1'b0;
    logic [UUID_W-1:0] i_cfg_target_uuid = '0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic              o_hid_found;
    logic              o_cfg_ready;

    int                fail_count;
    int                pending_results;
    int                cycle_count   = 0;
    int                phase_bytes;
    bit                quiet         = 1'b0;
    bit                frame_gaps    = 1'b0;
    bit                hold_off_req  = 1'b0;
    bit                hold_off_done = 1'b0;
    logic [UUID_W-1:0] cur_target;
    logic [7:0]        frame_q[$];

    adv_hid_service_scanner_core u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_data_byte       (i_data_byte),
        .i_last            (i_last),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_hid_found       (o_hid_found),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_target_uuid (i_cfg_target_uuid)
    );

    ahs_scan_checker u_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_data_byte       (i_data_byte),
        .i_last            (i_last),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_hid_found       (o_hid_found),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_target_uuid (i_cfg_target_uuid),
        .o_fail_count      (fail_count),
        .o_pending         (pending_results)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Keep valid high across back-to-back transfers; drop it only for a gap
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        if (frame_gaps && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last      <= is_last;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_frame();
        frame_gaps = !quiet && ($urandom_range(0, 2) != 0);
        foreach (frame_q[k]) begin
            send_byte(frame_q[k], k == frame_q.size() - 1);
        end
        phase_bytes += frame_q.size();
        frame_q.delete();
    endtask

    // Drop valid and wait until every found flag has come back
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_target(input logic [UUID_W-1:0] uuid);
        i_cfg_valid       <= 1'b1;
        i_cfg_target_uuid <= uuid;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_target = uuid;
    endtask

    task automatic push_pair(input bit hit);
        if (hit) begin
            frame_q.push_back(cur_target[7:0]);
            frame_q.push_back(cur_target[15:8]);
        end else begin
            frame_q.push_back(8'($urandom_range(0, 255)));
            frame_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic build_frame();
        int kind;
        int n_ent;
        int odd;
        int keep;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 24)) frame_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(1, 4)) begin
            kind = $urandom_range(0, 19);
            if (kind < 8) begin
                n_ent = $urandom_range(0, 4);
                odd   = ($urandom_range(0, 3) == 0);
                frame_q.push_back(8'(1 + 2 * n_ent + odd));
                frame_q.push_back(kind < 4 ? AD_UUID16_PARTIAL : AD_UUID16_FULL);
                repeat (n_ent) push_pair($urandom_range(0, 3) == 0);
                if (odd) begin
                    frame_q.push_back(cur_target[7:0]);
                end
            end else if (kind < 14) begin
                n_ent = $urandom_range(0, 2);
                frame_q.push_back(8'(1 + U128_ENTRY_LEN * n_ent));
                frame_q.push_back(AD_UUID128_FULL);
                repeat (n_ent) begin
                    repeat (int'(U128_LO_POS)) frame_q.push_back(8'($urandom_range(0, 255)));
                    push_pair($urandom_range(0, 2) == 0);
                    repeat (int'(U128_END_POS - U128_HI_POS)) begin
                        frame_q.push_back(8'($urandom_range(0, 255)));
                    end
                end
            end else if (kind < 18) begin
                n_ent = $urandom_range(0, 8);
                frame_q.push_back(8'(1 + n_ent));
                frame_q.push_back(8'($urandom_range(0, 255)));
                repeat (n_ent) frame_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                frame_q.push_back(8'h00);
            end
        end
        // cut the data short now and then
        if ($urandom_range(0, 4) == 0) begin
            keep = $urandom_range(1, frame_q.size());
            while (frame_q.size() > keep) void'(frame_q.pop_back());
        end
    endtask

    // Receiver: short random stalls, one long hold-off, none at the end
    initial begin : result_stall
        @(posedge i_clk);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                hold_off_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            @(posedge i_clk);
        end
    end

    initial begin : stimulus
        cur_target = UUID_RESET;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full pair in a complete 16-bit list
        frame_q = '{8'h03, AD_UUID16_FULL, UUID_RESET[7:0], UUID_RESET[15:8]};
        send_frame();
        // zero length, then a cut 16-bit list with an odd trailing byte
        frame_q = '{8'h00, 8'h05, AD_UUID16_PARTIAL, UUID_RESET[7:0], UUID_RESET[15:8],
                    8'hFF};
        send_frame();
        // 128-bit entry matching at bytes 12-13 but cut before its end
        frame_q = '{8'h11, AD_UUID128_FULL};
        for (int k = 0; k < int'(U128_LO_POS); k++) begin
            frame_q.push_back(k[0] ? 8'hFF : 8'h00);
        end
        frame_q.push_back(UUID_RESET[7:0]);
        frame_q.push_back(UUID_RESET[15:8]);
        send_frame();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph != 0) begin
                settle();
                case (ph)
                    1:       write_target(16'h0000);
                    2:       write_target(16'hFFFF);
                    default: write_target(UUID_W'($urandom_range(1, 16'hFFFE)));
                endcase
            end
            hold_off_req = (ph == 1);
            quiet        = (ph == N_PHASES - 1);
            phase_bytes  = 0;
            while (phase_bytes < BYTES_PER_PHASE) begin
                build_frame();
                send_frame();
            end
        end

        settle();
        if (fail_count == 0 && pending_results == 0) begin
            $display("Testbench completed without errors");
        end else begin
            if (pending_results != 0) begin
                $display("found flags still outstanding: %0d", pending_results);
            end
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
